/* src/qalu_pkg.sv */
package qalu_pkg;

    localparam logic [3:0] FN_ADD        = 4'd0;
    localparam logic [3:0] FN_SUB        = 4'd1;
    localparam logic [3:0] FN_MUL        = 4'd2;
    localparam logic [3:0] FN_DIV        = 4'd3;
    localparam logic [3:0] FN_MIN        = 4'd4;
    localparam logic [3:0] FN_MAX        = 4'd5;
    localparam logic [3:0] FN_INC        = 4'd6;
    localparam logic [3:0] FN_DEC        = 4'd7;
    localparam logic [3:0] FN_INT_TO_FIX = 4'd8;
    localparam logic [3:0] FN_FIX_TO_INT = 4'd9;
    localparam logic [3:0] FN_COMPARE    = 4'd10;

    localparam int WORD_W = 32;

    typedef struct packed {
        logic [3:0]               func;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     overflowed;
        logic                     divide_by_zero;
    } rsp_t;

    typedef struct packed {
        logic [3:0]               func;
        logic                     neg;
        logic signed [WORD_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     overflowed;
        logic                     divide_by_zero;
    } meta_t;

endpackage

/* src/fixed_point_q24_8_alu.sv */
// Signed fixed-point ALU, 32-bit words with FRAC_BITS fraction bits.
//
// Request channel: req_valid / req_ready / req_data carry an opcode and two
// raw operands. Response channel: rsp_valid / rsp_ready / rsp_data carry the
// result, the signed compare flags of operand_a against operand_b, and the
// overflow and divide-by-zero flags. Every request yields one response, in
// order.
//
// Throughput is one request per cycle for every opcode while the receiver
// does not stall. The stages are two front stages (operand setup and the
// 32x32 multiplier, then multiply rounding), one restoring divider cell per
// quotient bit (32 + FRAC_BITS cells, all opcodes pass through them), and
// the output register with divide rounding.
//
// Reset clears every stage's valid bit; the pipeline comes up empty and
// ready. When the receiver stalls, each stage holds its request and a stage
// takes new data as long as it or any stage after it has room, so bubbles
// close up and the response stays stable until taken.
module fixed_point_q24_8_alu
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int NUM_W = WORD_W + FRAC_BITS;

    logic              chain_valid [0:NUM_W];
    logic              chain_ready [0:NUM_W];
    meta_t             chain_meta  [0:NUM_W];
    logic [NUM_W-1:0]  chain_num   [0:NUM_W];
    logic [WORD_W-1:0] chain_rem   [0:NUM_W];
    logic [WORD_W-1:0] chain_den   [0:NUM_W];

    qalu_front #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_meta  (chain_meta[0]),
        .out_num   (chain_num[0]),
        .out_den   (chain_den[0])
    );

    assign chain_rem[0] = '0;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        qalu_div_cell #(
            .NUM_W (NUM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_meta   (chain_meta[i]),
            .in_num    (chain_num[i]),
            .in_rem    (chain_rem[i]),
            .in_den    (chain_den[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_meta  (chain_meta[i+1]),
            .out_num   (chain_num[i+1]),
            .out_rem   (chain_rem[i+1]),
            .out_den   (chain_den[i+1])
        );
    end

    qalu_back #(
        .NUM_W (NUM_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NUM_W]),
        .in_ready  (chain_ready[NUM_W]),
        .in_meta   (chain_meta[NUM_W]),
        .in_num    (chain_num[NUM_W]),
        .in_rem    (chain_rem[NUM_W]),
        .in_den    (chain_den[NUM_W]),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

/* src/qalu_front.sv */
module qalu_front
    import qalu_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 32 + FRAC_BITS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req_data,
    output logic              out_valid,
    input  logic              out_ready,
    output meta_t             out_meta,
    output logic [NUM_W-1:0]  out_num,
    output logic [WORD_W-1:0] out_den
);

    localparam logic [63:0] HALF     = 64'(1) << (FRAC_BITS - 1);
    localparam logic [63:0] POS_LIM  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] NEG_LIM  = 64'h0000_0000_8000_0000;

    logic              s1_valid_reg;
    meta_t             s1_meta_reg;
    meta_t             s1_meta_next;
    logic [63:0]       s1_prod_reg;
    logic [NUM_W-1:0]  s1_num_reg;
    logic [WORD_W-1:0] s1_den_reg;
    logic              s1_ready;

    logic              s2_valid_reg;
    meta_t             s2_meta_reg;
    meta_t             s2_meta_next;
    logic [NUM_W-1:0]  s2_num_reg;
    logic [WORD_W-1:0] s2_den_reg;
    logic              s2_ready;

    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic [WORD_W-1:0]        mag_a;
    logic [WORD_W-1:0]        mag_b;
    logic [WORD_W:0]          sum;
    logic [WORD_W:0]          diff;
    logic [FRAC_BITS:0]       a_top;
    logic [63:0]              prod_next;
    logic [63:0]              q_mul;

    assign a     = req_data.operand_a;
    assign b     = req_data.operand_b;
    assign mag_a = a[WORD_W-1] ? (~a + 32'd1) : a;
    assign mag_b = b[WORD_W-1] ? (~b + 32'd1) : b;
    assign sum   = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    assign diff  = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    assign a_top = a[WORD_W-1:WORD_W-1-FRAC_BITS];
    assign prod_next = mag_a * mag_b;

    always_comb
    begin
        s1_meta_next                = '0;
        s1_meta_next.func           = req_data.func;
        s1_meta_next.neg            = a[WORD_W-1] ^ b[WORD_W-1];
        s1_meta_next.a_less         = a < b;
        s1_meta_next.a_equal        = a == b;
        s1_meta_next.a_greater      = a > b;
        case (req_data.func)
            FN_ADD:
            begin
                s1_meta_next.result_value = sum[WORD_W-1:0];
                s1_meta_next.overflowed   = sum[WORD_W] ^ sum[WORD_W-1];
            end
            FN_SUB:
            begin
                s1_meta_next.result_value = diff[WORD_W-1:0];
                s1_meta_next.overflowed   = diff[WORD_W] ^ diff[WORD_W-1];
            end
            FN_DIV:
            begin
                s1_meta_next.divide_by_zero = b == 0;
            end
            FN_MIN:
            begin
                s1_meta_next.result_value = (a > b) ? b : a;
            end
            FN_MAX:
            begin
                s1_meta_next.result_value = (a < b) ? b : a;
            end
            FN_INC:
            begin
                s1_meta_next.result_value = a + 32'sd1;
                s1_meta_next.overflowed   = a == 32'sh7FFF_FFFF;
            end
            FN_DEC:
            begin
                s1_meta_next.result_value = a - 32'sd1;
                s1_meta_next.overflowed   = a == 32'sh8000_0000;
            end
            FN_INT_TO_FIX:
            begin
                s1_meta_next.result_value = a << FRAC_BITS;
                s1_meta_next.overflowed   = !((&a_top) || !(|a_top));
            end
            FN_FIX_TO_INT:
            begin
                s1_meta_next.result_value = a >>> FRAC_BITS;
            end
            default:
            begin
                s1_meta_next.result_value = '0;
            end
        endcase
    end

    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && s1_ready)
        begin
            s1_meta_reg <= s1_meta_next;
            s1_prod_reg <= prod_next;
            s1_num_reg  <= {mag_a, {FRAC_BITS{1'b0}}};
            s1_den_reg  <= mag_b;
        end
    end

    assign q_mul = (s1_prod_reg + HALF) >> FRAC_BITS;

    always_comb
    begin
        s2_meta_next = s1_meta_reg;
        if (s1_meta_reg.func == FN_MUL)
        begin
            if (s1_meta_reg.neg)
            begin
                s2_meta_next.overflowed   = q_mul > NEG_LIM;
                s2_meta_next.result_value = (q_mul > NEG_LIM) ? 32'sh8000_0000
                                                              : -q_mul[WORD_W-1:0];
            end
            else
            begin
                s2_meta_next.overflowed   = q_mul > POS_LIM;
                s2_meta_next.result_value = (q_mul > POS_LIM) ? 32'sh7FFF_FFFF
                                                              : q_mul[WORD_W-1:0];
            end
        end
    end

    assign s2_ready = !s2_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_meta_reg <= s2_meta_next;
            s2_num_reg  <= s1_num_reg;
            s2_den_reg  <= s1_den_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_meta  = s2_meta_reg;
    assign out_num   = s2_num_reg;
    assign out_den   = s2_den_reg;

endmodule

/* src/qalu_div_cell.sv */
module qalu_div_cell
    import qalu_pkg::*;
#(
    parameter int NUM_W = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  meta_t             in_meta,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [WORD_W-1:0] in_rem,
    input  logic [WORD_W-1:0] in_den,
    output logic              out_valid,
    input  logic              out_ready,
    output meta_t             out_meta,
    output logic [NUM_W-1:0]  out_num,
    output logic [WORD_W-1:0] out_rem,
    output logic [WORD_W-1:0] out_den
);

    logic              valid_reg;
    meta_t             meta_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] rem_next;
    logic [WORD_W-1:0] den_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_sub;
    logic              fits;

    assign trial     = {in_rem, in_num[NUM_W-1]};
    assign trial_sub = trial - {1'b0, in_den};
    assign fits      = trial >= {1'b0, in_den};
    assign rem_next  = fits ? trial_sub[WORD_W-1:0] : trial[WORD_W-1:0];
    assign num_next  = {in_num[NUM_W-2:0], fits};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meta_reg <= in_meta;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_meta  = meta_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

/* src/qalu_back.sv */
module qalu_back
    import qalu_pkg::*;
#(
    parameter int NUM_W = 40
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  meta_t             in_meta,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [WORD_W-1:0] in_rem,
    input  logic [WORD_W-1:0] in_den,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp_data
);

    localparam int Q_W = NUM_W + 1;
    localparam logic [Q_W-1:0] POS_LIM = Q_W'({1'b0, {31{1'b1}}});
    localparam logic [Q_W-1:0] NEG_LIM = Q_W'({1'b1, 31'b0});

    logic             valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             round_up;
    logic [Q_W-1:0]   q_div;

    assign round_up = {in_rem, 1'b0} >= {1'b0, in_den};
    assign q_div    = {1'b0, in_num} + Q_W'(round_up);

    always_comb
    begin
        rsp_next.result_value   = in_meta.result_value;
        rsp_next.a_less         = in_meta.a_less;
        rsp_next.a_equal        = in_meta.a_equal;
        rsp_next.a_greater      = in_meta.a_greater;
        rsp_next.overflowed     = in_meta.overflowed;
        rsp_next.divide_by_zero = in_meta.divide_by_zero;
        if (in_meta.func == FN_DIV && !in_meta.divide_by_zero)
        begin
            if (in_meta.neg)
            begin
                rsp_next.overflowed   = q_div > NEG_LIM;
                rsp_next.result_value = (q_div > NEG_LIM) ? 32'sh8000_0000
                                                          : -q_div[WORD_W-1:0];
            end
            else
            begin
                rsp_next.overflowed   = q_div > POS_LIM;
                rsp_next.result_value = (q_div > POS_LIM) ? 32'sh7FFF_FFFF
                                                          : q_div[WORD_W-1:0];
            end
        end
    end

    assign in_ready = !valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

/* src/qalu_checker.sv */
module qalu_checker
    import qalu_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req_data,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
        else $error("request changed while stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with empty output");

    a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot({rsp_data.a_less, rsp_data.a_equal, rsp_data.a_greater}))
        else $error("compare flags not one-hot");

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.divide_by_zero |->
            rsp_data.result_value == 0 && !rsp_data.overflowed)
        else $error("divide by zero response malformed");

endmodule

bind fixed_point_q24_8_alu qalu_checker u_qalu_checker (.*);

/* dv/fixed_point_q24_8_alu_tb.sv */
`default_nettype none

module fixed_point_q24_8_alu_tb;
    import qalu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 8;
    localparam logic [3:0] FN_UNUSED_LO = 4'd11;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;
    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam int RANDOM_PER_PHASE = 400;

    typedef struct {
        req_t req;
        logic typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req_data = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp_data;

    rsp_t pending_results[$];
    int unsigned send_idle_pct = 20;
    int unsigned recv_stall_pct = 46;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent = 0;

    stim_row_t directed_rows[] = '{
        '{'{FN_ADD, 32'h7fffffff, 32'h00000001}, 1'b1,
          '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FN_ADD, 32'h80000000, 32'hffffffff}, 1'b1,
          '{32'h7fffffff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{FN_ADD, 32'h00000100, 32'h00000200}, 1'b1,
          '{32'h00000300, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_SUB, 32'h80000000, 32'h00000001}, 1'b1,
          '{32'h7fffffff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{FN_SUB, 32'h7fffffff, 32'hffffffff}, 1'b1,
          '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FN_MUL, 32'h7fffffff, 32'h7fffffff}, 1'b1,
          '{32'h7fffffff, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{FN_MUL, 32'h80000000, 32'h7fffffff}, 1'b1,
          '{32'h80000000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{FN_MUL, 32'h80000000, 32'h80000000}, 1'b1,
          '{32'h7fffffff, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{FN_MUL, 32'h00000080, 32'h00000001}, 1'b0, '0},
        '{'{FN_MUL, 32'hffffff80, 32'h00000001}, 1'b0, '0},
        '{'{FN_DIV, 32'h00000100, 32'h00000000}, 1'b1,
          '{32'h00000000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
        '{'{FN_DIV, 32'h00000000, 32'h00000000}, 1'b1,
          '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{FN_DIV, 32'h7fffffff, 32'h00000001}, 1'b1,
          '{32'h7fffffff, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FN_DIV, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
        '{'{FN_DIV, 32'h00000001, 32'h00000200}, 1'b0, '0},
        '{'{FN_MIN, 32'h80000000, 32'h7fffffff}, 1'b1,
          '{32'h80000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_MAX, 32'h80000000, 32'h7fffffff}, 1'b1,
          '{32'h7fffffff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_INC, 32'h7fffffff, 32'h00000000}, 1'b1,
          '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FN_DEC, 32'h80000000, 32'h00000000}, 1'b1,
          '{32'h7fffffff, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{FN_INT_TO_FIX, 32'h007fffff, 32'h00000000}, 1'b1,
          '{32'h7fffff00, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{FN_INT_TO_FIX, 32'h00800000, 32'h00000000}, 1'b1,
          '{32'h80000000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0}},
        '{'{FN_INT_TO_FIX, 32'hff800000, 32'h00000000}, 1'b1,
          '{32'h80000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_FIX_TO_INT, 32'h80000000, 32'h00000000}, 1'b1,
          '{32'hff800000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_FIX_TO_INT, 32'hffffffff, 32'h00000000}, 1'b0, '0},
        '{'{FN_COMPARE, 32'h00000005, 32'h00000005}, 1'b1,
          '{32'h00000000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{'{FN_UNUSED_HI, 32'h00000001, 32'h00000002}, 1'b1,
          '{32'h00000000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{'{FN_UNUSED_LO, 32'h7fffffff, 32'h80000000}, 1'b0, '0}
    };

    fixed_point_q24_8_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // {overflow, word}
    function automatic logic [32:0] saturate_word(input logic neg, input logic [63:0] mag);
        if (neg)
        begin
            if (mag > 64'd2147483648)
                return {1'b1, 32'h80000000};
            return {1'b0, 32'(64'd0 - mag)};
        end
        if (mag > 64'd2147483647)
            return {1'b1, 32'h7fffffff};
        return {1'b0, mag[31:0]};
    endfunction

    function automatic rsp_t alu_result(input req_t r);
        longint a;
        longint b;
        longint wide;
        longint lim;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] quo;
        logic [32:0] sat;
        logic neg;
        rsp_t o;
        o = '0;
        a = $signed(r.operand_a);
        b = $signed(r.operand_b);
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        case (r.func)
            FN_ADD:
            begin
                wide = a + b;
                o.result_value = wide[31:0];
                o.overflowed = (wide > WORD_MAX) || (wide < WORD_MIN);
            end
            FN_SUB:
            begin
                wide = a - b;
                o.result_value = wide[31:0];
                o.overflowed = (wide > WORD_MAX) || (wide < WORD_MIN);
            end
            FN_MUL:
            begin
                quo = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                sat = saturate_word(neg, quo);
                {o.overflowed, o.result_value} = sat;
            end
            FN_DIV:
            begin
                if (b == 0)
                    o.divide_by_zero = 1'b1;
                else
                begin
                    quo = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
                    sat = saturate_word(neg, quo);
                    {o.overflowed, o.result_value} = sat;
                end
            end
            FN_MIN:
                o.result_value = (a > b) ? r.operand_b : r.operand_a;
            FN_MAX:
                o.result_value = (a < b) ? r.operand_b : r.operand_a;
            FN_INC:
            begin
                wide = a + 1;
                o.result_value = wide[31:0];
                o.overflowed = wide > WORD_MAX;
            end
            FN_DEC:
            begin
                wide = a - 1;
                o.result_value = wide[31:0];
                o.overflowed = wide < WORD_MIN;
            end
            FN_INT_TO_FIX:
            begin
                lim = 64'sd1 <<< (31 - FRAC_BITS);
                o.result_value = r.operand_a << FRAC_BITS;
                o.overflowed = (a < -lim) || (a > lim - 1);
            end
            FN_FIX_TO_INT:
                o.result_value = $signed(r.operand_a) >>> FRAC_BITS;
            default:
                o.result_value = '0;
        endcase
        o.a_less = a < b;
        o.a_equal = a == b;
        o.a_greater = a > b;
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 6))
                    0: return 32'h00000000;
                    1: return 32'h00000001;
                    2: return 32'hffffffff;
                    3: return 32'h7fffffff;
                    4: return 32'h80000000;
                    5: return 32'h00000100;
                    default: return 32'hffffff00;
                endcase
            end
            1, 2: return 32'($urandom_range(0, 2047)) - 32'd1024;
            3, 4: return {{16{r[15]}}, r[15:0]};
            default: return r;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endfunction

    task automatic issue_request(input req_t r, input rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(want);
        requests_sent++;
    endtask

    initial
    begin
        @(posedge clk);
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, rsp_data);
                end
                else
                begin
                    rsp_t want;
                    want = pending_results.pop_front();
                    check_field("result_value", want.result_value, rsp_data.result_value);
                    check_field("a_less", 32'(want.a_less), 32'(rsp_data.a_less));
                    check_field("a_equal", 32'(want.a_equal), 32'(rsp_data.a_equal));
                    check_field("a_greater", 32'(want.a_greater), 32'(rsp_data.a_greater));
                    check_field("overflowed", 32'(want.overflowed), 32'(rsp_data.overflowed));
                    check_field("divide_by_zero", 32'(want.divide_by_zero),
                                32'(rsp_data.divide_by_zero));
                    results_checked++;
                end
            end
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        req_t r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue_request(directed_rows[i].req,
                          directed_rows[i].typed ? directed_rows[i].want
                                                 : alu_result(directed_rows[i].req));

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_stall_pct = 46;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE)
            begin
                if ($urandom_range(0, 19) == 0)
                    r.func = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
                else
                    r.func = 4'($urandom_range(0, FN_COMPARE));
                r.operand_a = pick_operand();
                r.operand_b = pick_operand();
                if ($urandom_range(0, 7) == 0)
                    r.operand_b = r.operand_a;
                if (r.func == FN_DIV && $urandom_range(0, 9) == 0)
                    r.operand_b = '0;
                issue_request(r, alu_result(r));
            end
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (FRAC_BITS + 40) @(posedge clk);

        $display("Sent %0d requests (%0d directed, the rest random over three idle/stall mixes)",
                 requests_sent, directed_rows.size());
        $display("Checked %0d responses, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
